/* rtl/eemi_pkg.sv */
package eemi_pkg;

    localparam int OPND_W      = 31;
    localparam int COEF_W      = 32;
    localparam int RES_W       = 32;
    localparam int DVD_W       = 32;
    localparam int CNT_W       = $clog2(DVD_W);
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 128;

    typedef struct packed {
        logic load;
        logic div_step;
        logic euclid_next;
        logic euclid_end;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic b_zero;
        logic rem_zero;
        logic b_one;
    } t_sts;

    // A coefficient of the working width, truncated or sign-extended to the result width.
    function automatic logic [RES_W-1:0] fit_coef(input logic [COEF_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(signed'(v));
        return ext[RES_W-1:0];
    endfunction

endpackage

/* rtl/eemi_ctrl.sv */
module eemi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  eemi_pkg::t_sts  i_sts,
    output eemi_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]                 r_state, n_state;
    logic [eemi_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_out_vld, n_out_vld;
    logic                       last;
    logic                       slot_free;

    assign last       = (r_cnt == eemi_pkg::CNT_W'(eemi_pkg::DVD_W - 1));
    assign slot_free  = !r_out_vld || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld;
        o_cmd     = '0;
        if (i_m_tready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_cnt   = '0;
                n_state = i_sts.b_zero ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_cnt = '0;
                if (i_sts.rem_zero) begin
                    o_cmd.euclid_end = 1'b1;
                    n_state          = i_sts.b_one ? S_MOD : S_FIN;
                end else begin
                    o_cmd.euclid_next = 1'b1;
                    n_state           = S_DIV;
                end
            end
            S_MOD: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.capture = 1'b1;
                    n_out_vld     = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

/* rtl/eemi_dp.sv */
module eemi_dp (
    input  logic                         i_clk,
    input  eemi_pkg::t_cmd               i_cmd,
    input  logic [eemi_pkg::OPND_W-1:0]  i_value_a,
    input  logic [eemi_pkg::OPND_W-1:0]  i_value_b,
    output eemi_pkg::t_sts               o_sts,
    output logic [eemi_pkg::OPND_W-1:0]  o_divisor_result,
    output logic [eemi_pkg::RES_W-1:0]   o_coef_x,
    output logic [eemi_pkg::RES_W-1:0]   o_coef_y,
    output logic [eemi_pkg::OPND_W-1:0]  o_inverse,
    output logic                         o_has_inverse,
    output logic                         o_zero_modulus
);

    localparam int OW = eemi_pkg::OPND_W;
    localparam int CW = eemi_pkg::COEF_W;
    localparam int RW = eemi_pkg::RES_W;
    localparam int DW = eemi_pkg::DVD_W;

    logic [OW-1:0] r_g, r_b, r_m, r_rem;
    logic [DW-1:0] r_dvd;
    logic [CW-1:0] r_px, r_cx, r_py, r_cy, r_qx, r_qy;
    logic          r_zero, r_has;
    logic [OW-1:0] r_o_g, r_o_inv;
    logic [RW-1:0] r_o_x, r_o_y;
    logic          r_o_has, r_o_zero;

    logic [OW:0]   rem2, diff;
    logic          ge;
    logic [RW-1:0] x32, y32, x_abs;
    logic [OW-1:0] inv_val;

    assign rem2  = {r_rem, r_dvd[DW-1]};
    assign diff  = rem2 - {1'b0, r_b};
    assign ge    = (rem2 >= {1'b0, r_b});
    assign x32   = eemi_pkg::fit_coef(r_cx);
    assign y32   = eemi_pkg::fit_coef(r_cy);
    assign x_abs = x32[RW-1] ? (~x32 + 1'b1) : x32;

    always_comb begin
        if (!r_has) begin
            inv_val = '0;
        end else if (x32[RW-1] && (r_rem != '0)) begin
            inv_val = r_m - r_rem;
        end else begin
            inv_val = r_rem;
        end
    end

    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.b_one    = (r_b == OW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvd  <= DW'(i_value_a);
            r_b    <= i_value_b;
            r_m    <= i_value_b;
            r_g    <= i_value_a;
            r_rem  <= '0;
            r_qx   <= '0;
            r_qy   <= '0;
            r_px   <= CW'(1);
            r_py   <= '0;
            r_cx   <= (i_value_b == '0) ? CW'(1) : '0;
            r_cy   <= (i_value_b == '0) ? '0 : CW'(1);
            r_zero <= (i_value_b == '0);
            r_has  <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? diff[OW-1:0] : rem2[OW-1:0];
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_qx  <= {r_qx[CW-2:0], 1'b0} + (ge ? r_cx : '0);
            r_qy  <= {r_qy[CW-2:0], 1'b0} + (ge ? r_cy : '0);
        end
        if (i_cmd.euclid_next) begin
            r_px  <= r_cx;
            r_cx  <= r_px - r_qx;
            r_py  <= r_cy;
            r_cy  <= r_py - r_qy;
            r_b   <= r_rem;
            r_dvd <= DW'(r_b);
            r_rem <= '0;
            r_qx  <= '0;
            r_qy  <= '0;
        end
        if (i_cmd.euclid_end) begin
            r_g   <= r_b;
            r_has <= (r_b == OW'(1));
            r_dvd <= DW'(x_abs);
            r_b   <= r_m;
            r_rem <= '0;
        end
        if (i_cmd.capture) begin
            r_o_g    <= r_g;
            r_o_x    <= x32;
            r_o_y    <= y32;
            r_o_inv  <= inv_val;
            r_o_has  <= r_has;
            r_o_zero <= r_zero;
        end
    end

    assign o_divisor_result = r_o_g;
    assign o_coef_x         = r_o_x;
    assign o_coef_y         = r_o_y;
    assign o_inverse        = r_o_inv;
    assign o_has_inverse    = r_o_has;
    assign o_zero_modulus   = r_o_zero;

endmodule

/* rtl/extended_euclid_modular_inverse.sv */
// Computes the gcd of a and b, Bezout coefficients x and y with a*x + b*y = gcd, and the least
// non-negative inverse of a modulo b, which is flagged as present only when the gcd is one.
// A zero b is flagged as a zero modulus and gives gcd = a, x = 1, y = 0. One word is worked on
// at a time: a shared restoring divider retires one quotient bit per cycle, and every Euclid
// round is 32 divide steps and one coefficient update, after which a word with a gcd of one
// spends 32 more divide steps reducing x modulo b. The next word is accepted as soon as the
// result has been moved to the output register, while that result still waits to be taken.
module extended_euclid_modular_inverse (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // value_a [30:0], value_b [61:31], zeros [63:62]
    input  logic [eemi_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // divisor_result [30:0], coef_x [62:31], coef_y [94:63], inverse [125:95],
    // has_inverse [126], zero_modulus [127]
    output logic [eemi_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int OW = eemi_pkg::OPND_W;
    localparam int RW = eemi_pkg::RES_W;

    eemi_pkg::t_cmd cmd;
    eemi_pkg::t_sts sts;
    logic [OW-1:0]  divisor_result, inverse;
    logic [RW-1:0]  coef_x, coef_y;
    logic           has_inverse, zero_modulus;

    eemi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    eemi_dp u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_value_a        (i_s_tdata[OW-1:0]),
        .i_value_b        (i_s_tdata[2*OW-1:OW]),
        .o_sts            (sts),
        .o_divisor_result (divisor_result),
        .o_coef_x         (coef_x),
        .o_coef_y         (coef_y),
        .o_inverse        (inverse),
        .o_has_inverse    (has_inverse),
        .o_zero_modulus   (zero_modulus)
    );

    assign o_m_tdata = {zero_modulus, has_inverse, inverse, coef_y, coef_x, divisor_result};

endmodule

/* rtl/eemi_chk.sv */
module eemi_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [eemi_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [eemi_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // Field positions within the result word.
    logic [30:0] g_f, inv_f;
    logic [31:0] x_f, y_f;
    logic        has_f, zero_f;

    assign g_f    = o_m_tdata[30:0];
    assign x_f    = o_m_tdata[62:31];
    assign y_f    = o_m_tdata[94:63];
    assign inv_f  = o_m_tdata[125:95];
    assign has_f  = o_m_tdata[126];
    assign zero_f = o_m_tdata[127];

    a_rst_idle: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed or dropped");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second word accepted while one is in progress");

    a_inv_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (has_f ? (g_f == 31'd1 && !zero_f) : (inv_f == 31'd0)))
        else $error("inverse flag disagrees with gcd or inverse");

    a_zero_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && zero_f |-> x_f == 32'd1 && y_f == 32'd0)
        else $error("zero modulus word has wrong coefficients");

endmodule

bind extended_euclid_modular_inverse eemi_chk u_eemi_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
